// ===== rtl/core/linear_scan_register_allocator_core_assert.svh =====
// Assertion macros for the linear-scan allocator core
`ifndef LINEAR_SCAN_REGISTER_ALLOCATOR_CORE_ASSERT_SVH
`define LINEAR_SCAN_REGISTER_ALLOCATOR_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define LSRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define LSRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lsra_pkg.sv =====
// ----------------------------------------------------------------------------
// lsra_pkg
// Shared types, constants and the register order for the allocator core.
// ----------------------------------------------------------------------------
package lsra_pkg;

    localparam int NUM_PHYS_REGS_DEF = 9;
    localparam int VREG_WIDTH_DEF    = 16;
    localparam int POS_WIDTH_DEF     = 16;
    localparam int PHYS_W            = 4;
    localparam int SLOT_W            = 16;
    localparam logic [SLOT_W-1:0] SLOT_MAX = '1;

    typedef struct packed {
        logic [15:0] virtual_reg;
        logic [15:0] first_use;
        logic [15:0] last_use;
    } in_item_t;

    typedef struct packed {
        logic [15:0] assigned_vreg;
        logic [3:0]  phys_reg;
        logic        is_spilled;
        logic [15:0] stack_slot;
        logic        evicted_valid;
        logic [15:0] evicted_vreg;
        logic [15:0] evicted_slot;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_DECIDE,
        ST_INSERT,
        ST_OUTPUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic expire;    // compact active list, push expired regs
        logic decide;    // pop / evict / spill decision
        logic insert;    // shift-insert new entry
        logic emit;      // load output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic do_insert; // decision needs an insert
    } stat_t;

    // reset order of the free stack: RAX RCX RDX RSI RDI R8..R11 RBX R12..R15 RSP RBP
    function automatic logic [PHYS_W-1:0] reg_order(input logic [3:0] i);
        logic [PHYS_W-1:0] r;
        case (i)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd1;
            4'd2:    r = 4'd2;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd7;
            4'd5:    r = 4'd8;
            4'd6:    r = 4'd9;
            4'd7:    r = 4'd10;
            4'd8:    r = 4'd11;
            4'd9:    r = 4'd3;
            4'd10:   r = 4'd12;
            4'd11:   r = 4'd13;
            4'd12:   r = 4'd14;
            4'd13:   r = 4'd15;
            4'd14:   r = 4'd4;
            default: r = 4'd5;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/lsra_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsra_ctrl
// Sequencer: accept, expire, decide, insert, hand result to output register.
// ----------------------------------------------------------------------------
`include "linear_scan_register_allocator_core_assert.svh"

module lsra_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            out_busy,
    input  lsra_pkg::stat_t stat,
    output lsra_pkg::cmd_t  cmd
);

    lsra_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsra_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            lsra_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lsra_pkg::ST_EXPIRE;
                end
            end
            lsra_pkg::ST_EXPIRE:
            begin
                cmd.expire = 1'b1;
                state_next = lsra_pkg::ST_DECIDE;
            end
            lsra_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.do_insert ? lsra_pkg::ST_INSERT : lsra_pkg::ST_OUTPUT;
            end
            lsra_pkg::ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = lsra_pkg::ST_OUTPUT;
            end
            lsra_pkg::ST_OUTPUT:
            begin
                if (!out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = lsra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsra_pkg::ST_IDLE;
            end
        endcase
    end

    `LSRA_ASSERT_NXT(a_load_to_expire, clk, rst_n, cmd.load, state_reg == lsra_pkg::ST_EXPIRE, "load must be followed by expire")
    `LSRA_ASSERT_IMP(a_stall_when_busy, clk, rst_n, state_reg != lsra_pkg::ST_IDLE, in_stall, "input taken while busy")
    `LSRA_ASSERT_NXT(a_expire_to_decide, clk, rst_n, cmd.expire, cmd.decide, "expire must be followed by decide")

endmodule

// ===== rtl/core/lsra_dp.sv =====
// ----------------------------------------------------------------------------
// lsra_dp
// Datapath: free stack, sorted active list, slot counter, output register.
// ----------------------------------------------------------------------------
`include "linear_scan_register_allocator_core_assert.svh"

module lsra_dp #(
    parameter int NUM_PHYS_REGS = lsra_pkg::NUM_PHYS_REGS_DEF,
    parameter int VREG_WIDTH    = lsra_pkg::VREG_WIDTH_DEF,
    parameter int POS_WIDTH     = lsra_pkg::POS_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lsra_pkg::in_item_t  in_data,
    input  lsra_pkg::cmd_t      cmd,
    output lsra_pkg::stat_t     stat,
    input  logic                out_stall,
    output logic                out_valid,
    output logic                out_busy,
    output lsra_pkg::out_item_t out_data
);

    localparam int N  = NUM_PHYS_REGS;
    localparam int CW = $clog2(N + 1);
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int PW = lsra_pkg::PHYS_W;

    logic [PW-1:0]         free_stack_reg [N];
    logic [CW-1:0]         free_count_reg;
    logic [VREG_WIDTH-1:0] act_vreg_reg [N];
    logic [POS_WIDTH-1:0]  act_end_reg  [N];
    logic [PW-1:0]         act_phys_reg [N];
    logic [CW-1:0]         act_count_reg;
    logic [lsra_pkg::SLOT_W-1:0] slot_reg;

    logic [VREG_WIDTH-1:0] vreg_reg;
    logic [POS_WIDTH-1:0]  start_reg, end_reg;
    logic [PW-1:0]         phys_reg_r;
    logic                  spill_reg, ev_valid_reg;
    logic [VREG_WIDTH-1:0] ev_vreg_reg;
    logic [lsra_pkg::SLOT_W-1:0] slot_out_reg, ev_slot_reg;
    logic                  ins_reg;

    // expiry compaction: keep flags, write indices by prefix count
    logic [N-1:0]          keep;
    logic [CW-1:0]         wpos [N];
    logic [CW-1:0]         fpos [N];
    logic [CW-1:0]         kept_cnt, exp_cnt;

    // decision
    logic [IW-1:0]         top_idx, last_idx;
    logic                  evict_ok;
    logic [lsra_pkg::SLOT_W-1:0] slot_inc;

    // insertion: entries whose end is greater shift up
    logic [N-1:0]          gt;

    always_comb
    begin
        kept_cnt = '0;
        exp_cnt  = '0;
        for (int i = 0; i < N; i++)
        begin
            keep[i] = (CW'(i) < act_count_reg) && !(act_end_reg[i] < start_reg);
            wpos[i] = kept_cnt;
            fpos[i] = free_count_reg + exp_cnt;
            if (CW'(i) < act_count_reg)
            begin
                if (keep[i])
                begin
                    kept_cnt = kept_cnt + 1'b1;
                end
                else
                begin
                    exp_cnt = exp_cnt + 1'b1;
                end
            end
        end
    end

    assign top_idx  = IW'(free_count_reg - 1'b1);
    assign last_idx = IW'(act_count_reg - 1'b1);
    assign evict_ok = (act_count_reg != '0) && (act_end_reg[last_idx] > end_reg);
    assign slot_inc = (slot_reg != lsra_pkg::SLOT_MAX) ? slot_reg + 1'b1 : slot_reg;
    assign stat.do_insert = (free_count_reg != '0) || evict_ok;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            gt[i] = (CW'(i) < act_count_reg) && (act_end_reg[i] > end_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= CW'(N);
            act_count_reg  <= '0;
            slot_reg       <= '0;
            out_valid      <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                free_stack_reg[i] <= lsra_pkg::reg_order(4'(i));
            end
        end
        else
        begin
            if (cmd.expire)
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (CW'(i) < act_count_reg)
                    begin
                        if (!keep[i] && fpos[i] < CW'(N))
                        begin
                            free_stack_reg[IW'(fpos[i])] <= act_phys_reg[i];
                        end
                    end
                end
                free_count_reg <= (free_count_reg + exp_cnt > CW'(N)) ? CW'(N)
                                  : free_count_reg + exp_cnt;
                act_count_reg  <= kept_cnt;
            end
            if (cmd.decide)
            begin
                if (free_count_reg != '0)
                begin
                    free_count_reg <= free_count_reg - 1'b1;
                end
                else if (evict_ok)
                begin
                    act_count_reg <= act_count_reg - 1'b1;
                    slot_reg      <= slot_inc;
                end
                else
                begin
                    slot_reg <= slot_inc;
                end
            end
            if (cmd.insert)
            begin
                act_count_reg <= act_count_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vreg_reg  <= VREG_WIDTH'(in_data.virtual_reg);
            start_reg <= POS_WIDTH'(in_data.first_use);
            end_reg   <= POS_WIDTH'(in_data.last_use);
        end
        if (cmd.expire)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (keep[i])
                begin
                    act_vreg_reg[IW'(wpos[i])] <= act_vreg_reg[i];
                    act_end_reg[IW'(wpos[i])]  <= act_end_reg[i];
                    act_phys_reg[IW'(wpos[i])] <= act_phys_reg[i];
                end
            end
        end
        if (cmd.decide)
        begin
            ins_reg <= stat.do_insert;
            if (free_count_reg != '0)
            begin
                phys_reg_r   <= free_stack_reg[top_idx];
                spill_reg    <= 1'b0;
                slot_out_reg <= '0;
                ev_valid_reg <= 1'b0;
                ev_vreg_reg  <= '0;
                ev_slot_reg  <= '0;
            end
            else if (evict_ok)
            begin
                phys_reg_r   <= act_phys_reg[last_idx];
                spill_reg    <= 1'b0;
                slot_out_reg <= '0;
                ev_valid_reg <= 1'b1;
                ev_vreg_reg  <= act_vreg_reg[last_idx];
                ev_slot_reg  <= slot_reg;
            end
            else
            begin
                phys_reg_r   <= '0;
                spill_reg    <= 1'b1;
                slot_out_reg <= slot_reg;
                ev_valid_reg <= 1'b0;
                ev_vreg_reg  <= '0;
                ev_slot_reg  <= '0;
            end
        end
        if (cmd.insert)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (gt[i] && i + 1 < N)
                begin
                    act_vreg_reg[(i + 1) % N] <= act_vreg_reg[i];
                    act_end_reg[(i + 1) % N]  <= act_end_reg[i];
                    act_phys_reg[(i + 1) % N] <= act_phys_reg[i];
                end
                // new entry goes to the lowest slot that is shifted or the end
                if ((gt[i] && (i == 0 || !gt[(i + N - 1) % N]))
                    || (CW'(i) == act_count_reg && (i == 0 || !gt[(i + N - 1) % N])))
                begin
                    act_vreg_reg[i] <= vreg_reg;
                    act_end_reg[i]  <= end_reg;
                    act_phys_reg[i] <= phys_reg_r;
                end
            end
        end
        if (cmd.emit)
        begin
            out_data.assigned_vreg <= 16'(vreg_reg);
            out_data.phys_reg      <= phys_reg_r;
            out_data.is_spilled    <= spill_reg;
            out_data.stack_slot    <= slot_out_reg;
            out_data.evicted_valid <= ev_valid_reg;
            out_data.evicted_vreg  <= 16'(ev_vreg_reg);
            out_data.evicted_slot  <= ev_slot_reg;
        end
    end

    assign out_busy = out_valid && out_stall;

    `LSRA_ASSERT_IMP(a_count_sum, clk, rst_n, !cmd.decide && !cmd.insert, CW'(free_count_reg + act_count_reg) == CW'(N), "free plus active must cover all registers")
    `LSRA_ASSERT_NXT(a_insert_flag, clk, rst_n, cmd.insert, ins_reg, "insert without a register")
    `LSRA_ASSERT_NXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid, "result not presented")

endmodule

// ===== rtl/core/linear_scan_register_allocator_core.sv =====
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_core
// Linear-scan allocator: one live interval in, one allocation result out.
// ----------------------------------------------------------------------------
//  channel | signals                    | direction
//  in      | in_valid/in_stall/in_data  | interval transfer into the core
//  out     | out_valid/out_stall/out_data | allocation result transfer out
//
//  From one accepted transfer to the next the core runs accept, expire,
//  decide, insert and output when the interval gets or steals a register,
//  and skips insert when it is spilled; one interval at a time.
//  All active entries expire together in the expire state.
//  Reset: free stack loads the fixed register order, lists empty.
//  A stalled result holds in the output register; the next transfer in
//  is taken once the result has been handed to it.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_core #(
    parameter int NUM_PHYS_REGS = lsra_pkg::NUM_PHYS_REGS_DEF,
    parameter int VREG_WIDTH    = lsra_pkg::VREG_WIDTH_DEF,
    parameter int POS_WIDTH     = lsra_pkg::POS_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lsra_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output lsra_pkg::out_item_t out_data
);

    lsra_pkg::cmd_t  cmd;
    lsra_pkg::stat_t stat;
    logic            out_busy;

    lsra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_busy (out_busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    lsra_dp #(
        .NUM_PHYS_REGS (NUM_PHYS_REGS),
        .VREG_WIDTH    (VREG_WIDTH),
        .POS_WIDTH     (POS_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_busy  (out_busy),
        .out_data  (out_data)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives live intervals into the allocator core with random bursts and
// output stalls; an internal allocator model predicts every result.
// ----------------------------------------------------------------------------

// Allocation predictor plus queue of pending results.
class alloc_scoreboard;
    logic [3:0]  free_regs [9];
    int          free_cnt;
    logic [15:0] act_vreg [9];
    logic [15:0] act_end [9];
    logic [3:0]  act_phys [9];
    int          act_cnt;
    logic [15:0] next_slot;
    lsra_pkg::out_item_t pending[$];
    int          errors;

    function void clear();
        logic [3:0] order [9];
        order = '{4'd0, 4'd1, 4'd2, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11};
        foreach (order[i]) free_regs[i] = order[i];
        free_cnt = 9;
        act_cnt = 0;
        next_slot = '0;
        errors = 0;
        pending.delete();
    endfunction

    function logic [15:0] grab_slot();
        logic [15:0] s;
        s = next_slot;
        if (next_slot != lsra_pkg::SLOT_MAX)
            next_slot++;
        return s;
    endfunction

    // Stable insert: goes after every entry whose end is not greater.
    function void place(logic [15:0] vreg, logic [15:0] last, logic [3:0] phys);
        int pos;
        pos = act_cnt;
        while (pos > 0 && act_end[pos-1] > last)
            pos--;
        for (int k = act_cnt; k > pos; k--)
        begin
            act_vreg[k] = act_vreg[k-1];
            act_end[k] = act_end[k-1];
            act_phys[k] = act_phys[k-1];
        end
        act_vreg[pos] = vreg;
        act_end[pos] = last;
        act_phys[pos] = phys;
        act_cnt++;
    endfunction

    function void note_interval(lsra_pkg::in_item_t it);
        lsra_pkg::out_item_t r;
        int w;
        r = '0;
        r.assigned_vreg = it.virtual_reg;
        w = 0;
        for (int i = 0; i < act_cnt; i++)
        begin
            if (act_end[i] < it.first_use)
            begin
                free_regs[free_cnt] = act_phys[i];
                free_cnt++;
            end
            else
            begin
                act_vreg[w] = act_vreg[i];
                act_end[w] = act_end[i];
                act_phys[w] = act_phys[i];
                w++;
            end
        end
        act_cnt = w;
        if (free_cnt > 0)
        begin
            free_cnt--;
            r.phys_reg = free_regs[free_cnt];
            place(it.virtual_reg, it.last_use, r.phys_reg);
        end
        else if (act_cnt > 0 && act_end[act_cnt-1] > it.last_use)
        begin
            act_cnt--;
            r.phys_reg = act_phys[act_cnt];
            r.evicted_valid = 1'b1;
            r.evicted_vreg = act_vreg[act_cnt];
            r.evicted_slot = grab_slot();
            place(it.virtual_reg, it.last_use, r.phys_reg);
        end
        else
        begin
            r.is_spilled = 1'b1;
            r.stack_slot = grab_slot();
        end
        pending = {pending, r};
    endfunction

    function void check_result(lsra_pkg::out_item_t got);
        lsra_pkg::out_item_t exp_r;
        if (pending.size() == 0)
        begin
            $error("unexpected result vreg=%0d", got.assigned_vreg);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.assigned_vreg !== exp_r.assigned_vreg)
        begin
            $error("assigned_vreg exp %0d got %0d", exp_r.assigned_vreg, got.assigned_vreg);
            errors++;
        end
        if (got.phys_reg !== exp_r.phys_reg)
        begin
            $error("phys_reg exp %0d got %0d", exp_r.phys_reg, got.phys_reg);
            errors++;
        end
        if (got.is_spilled !== exp_r.is_spilled)
        begin
            $error("is_spilled exp %0d got %0d", exp_r.is_spilled, got.is_spilled);
            errors++;
        end
        if (got.stack_slot !== exp_r.stack_slot)
        begin
            $error("stack_slot exp %0d got %0d", exp_r.stack_slot, got.stack_slot);
            errors++;
        end
        if (got.evicted_valid !== exp_r.evicted_valid)
        begin
            $error("evicted_valid exp %0d got %0d", exp_r.evicted_valid,
                   got.evicted_valid);
            errors++;
        end
        if (got.evicted_vreg !== exp_r.evicted_vreg)
        begin
            $error("evicted_vreg exp %0d got %0d", exp_r.evicted_vreg, got.evicted_vreg);
            errors++;
        end
        if (got.evicted_slot !== exp_r.evicted_slot)
        begin
            $error("evicted_slot exp %0d got %0d", exp_r.evicted_slot, got.evicted_slot);
            errors++;
        end
    endfunction
endclass

module testbench;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    lsra_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    lsra_pkg::out_item_t out_data;

    alloc_scoreboard sb;
    int  cycles;
    bit  hold_off;       // long output stall, requested by the stimulus
    logic [15:0] pos;    // current first use, nondecreasing in sequences

    linear_scan_register_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // One transfer: hold valid until accepted. Valid stays high between
    // back-to-back items, so it is lowered only when a gap follows.
    task automatic send(input lsra_pkg::in_item_t it, input bit gap_next);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_interval(it);
        if (gap_next)
            in_valid <= 1'b0;
    endtask

    task automatic idle(input int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_iv(input logic [15:0] v, input logic [15:0] f,
                           input logic [15:0] l, input bit gap_next);
        lsra_pkg::in_item_t it;
        it.virtual_reg = v;
        it.first_use = f;
        it.last_use = l;
        send(it, gap_next);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: own stall pattern, plus a long hold-off on request.
    initial
    begin
        int mode;
        int run;
        out_stall <= 1'b0;
        mode = 0;
        run = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                for (int i = 0; i < 300; i++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            if (run == 0)
            begin
                mode = $urandom_range(0, 3);
                run = $urandom_range(1, 40);
            end
            run--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 5) != 0);
            endcase
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Bursty random intervals; mostly sorted by first use, a few noisy.
    task automatic random_phase(input int count);
        int burst;
        lsra_pkg::in_item_t it;
        bit gap;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
                burst = $urandom_range(1, 20);
            burst--;
            it.virtual_reg = 16'($urandom);
            if ($urandom_range(0, 19) == 0)
            begin
                it.first_use = 16'($urandom);
                it.last_use = 16'($urandom);
            end
            else
            begin
                if (pos < 16'hFF00)
                    pos = pos + 16'($urandom_range(0, 3));
                else
                    pos = 16'($urandom_range(0, 15));
                it.first_use = pos;
                case ($urandom_range(0, 5))
                    0: it.last_use = pos;
                    1: it.last_use = pos + 16'($urandom_range(0, 255));
                    2: it.last_use = (pos > 16'd3) ? pos - 16'd3 : 16'hFFFF;
                    default: it.last_use = pos + 16'($urandom_range(0, 40));
                endcase
            end
            gap = (burst == 0) && (n != count - 1);
            send(it, gap || n == count - 1);
            if (gap)
                idle($urandom_range(1, 12));
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        cycles = 0;
        hold_off = 1'b0;
        pos = '0;
        in_valid <= 1'b0;
        in_data  <= '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill all nine registers, then evict and spill.
        for (int i = 0; i < 9; i++)
            send_iv(16'(16'h0010 + i), 16'd10, 16'(16'd100 + i), 1'b0);
        send_iv(16'hFFFF, 16'd10, 16'd50, 1'b0);    // evicts the latest end
        send_iv(16'h0000, 16'd10, 16'd108, 1'b0);   // end later than all active: spill
        send_iv(16'h0020, 16'd10, 16'hFFFF, 1'b0);  // later end: spill
        send_iv(16'h0021, 16'd50, 16'd0, 1'b0);     // end equals start: no expiry
        send_iv(16'h0022, 16'd51, 16'd60, 1'b0);    // expiry of end 50
        send_iv(16'h0023, 16'd5, 16'd2, 1'b0);      // decreasing first use
        send_iv(16'hAAAA, 16'hFFFF, 16'hFFFF, 1'b0);// expire all active
        send_iv(16'h5555, 16'hFFFF, 16'h0000, 1'b1);
        wait_drained();

        // Pressure: long output hold while the sender keeps offering items.
        hold_off = 1'b1;
        random_phase(60);
        wait_drained();

        // Exercise the slot counter using spills: all 9 active
        // with end FFFF, then keep spilling equal ends.
        for (int i = 0; i < 9; i++)
            send_iv(16'($urandom), 16'hFFFF, 16'hFFFF, 1'b0);
        for (int i = 0; i < 150; i++)
            send_iv(16'($urandom), 16'hFFFF, 16'hFFFF, i == 149);
        wait_drained();
        // fast forward is not possible through ports; saturation is
        // reached only if the stream is long, so continue with random load
        pos = '0;
        random_phase(1700);
        wait_drained();
        idle(20);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
